// ===== rtl/sla_pkg.sv =====
// Package with the shared constants, codes and types of the serial line assembler.
`timescale 1ns / 1ps
package sla_pkg;

   localparam int MAX_DEPTH = 256;
   localparam int ADDR_W    = $clog2(MAX_DEPTH);
   localparam int LEN_W     = 9;
   localparam int CAP_W     = 9;
   localparam int IDX_W     = 2;

   localparam logic [7:0] CH_BS    = 8'h08;
   localparam logic [7:0] CH_DEL   = 8'h7f;
   localparam logic [7:0] CH_BRACE = 8'h7b;
   localparam logic [7:0] CH_CR    = 8'h0d;
   localparam logic [7:0] CH_NUL   = 8'h00;
   localparam logic [7:0] CH_LF    = 8'h0a;

   localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(MAX_DEPTH);

   typedef enum logic [1:0] {
      OP_RECEIVE = 2'd0,
      OP_CLEAR   = 2'd1,
      OP_READ    = 2'd2
   } opcode_type;

   typedef enum logic [IDX_W-1:0] {
      CSR_CAPACITY    = 2'd0,
      CSR_ECHO_ENABLE = 2'd1
   } csr_index_type;

   typedef enum logic [1:0] {
      ST_EMPTY    = 2'd0,
      ST_PARTIAL  = 2'd1,
      ST_READY    = 2'd2,
      ST_OVERFLOW = 2'd3
   } status_type;

   // Result of one request, carried from the decode stage to the output register.
   typedef struct packed {
      logic             echo_valid;
      logic [7:0]       echo_byte;
      logic             accepted;
      logic             rd_hit;
      status_type       status;
      logic [LEN_W-1:0] length;
      logic             dual;
   } rsp_info_type;

endpackage

// ===== rtl/sla_if.sv =====
// Handshake channel interfaces for requests, results and register writes.
`timescale 1ns / 1ps
interface sla_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] opcode;
   logic [7:0] rx_byte;
   logic [7:0] read_index;

   modport source (output valid, opcode, rx_byte, read_index, input ready);
   modport sink (input valid, opcode, rx_byte, read_index, output ready);
endinterface

interface sla_rsp_if;
   logic       valid;
   logic       ready;
   logic       echo_valid;
   logic [7:0] echo_byte;
   logic       accepted;
   logic [7:0] read_data;
   logic [1:0] status;
   logic [8:0] length;
   logic       last;

   modport source (output valid, echo_valid, echo_byte, accepted, read_data, status,
                   length, last, input ready);
   modport sink (input valid, echo_valid, echo_byte, accepted, read_data, status,
                 length, last, output ready);
endinterface

interface sla_csr_if;
   logic       valid;
   logic       ready;
   logic [1:0] index;
   logic [8:0] data;

   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

// ===== rtl/serial_line_assembler_with_echo.sv =====
// Top level: line assembly with backspace, echo and a line store in one memory.
// A result passes the decode register, then the output register, which holds it until
// it is taken and so sets the rate: one request per cycle while results are taken.
// A backspace with echo occupies the output for a backspace and then a delete.
// Reset clears fill level, flags, the pipeline and sets capacity 256, echo off.
// The line store is not cleared at reset; entries read back only once written.
`timescale 1ns / 1ps
module serial_line_assembler_with_echo (
   input logic      clock,
   input logic      reset,
   sla_req_if.sink  req_if,
   sla_rsp_if.source rsp_if,
   sla_csr_if.sink  csr_if
);
   import sla_pkg::*;

   logic [7:0]       store_mem [MAX_DEPTH];
   logic [7:0]       mem_q_ff;

   logic [CAP_W-1:0] capacity_ff;
   logic             echo_en_ff;

   logic [LEN_W-1:0] fill_ff, fill_in;
   logic             ready_ff, ready_in;
   logic             ovf_ff, ovf_in;
   logic             echo_act_ff, echo_act_in;
   logic             lf_pend_ff, lf_pend_in;

   logic             s1_valid_ff;
   rsp_info_type     s1_ff, s1_in;

   logic             out_valid_ff;
   logic             out_last_ff;
   rsp_info_type     out_ff;
   logic [7:0]       out_rdata_ff;

   logic             req_accept, out_free, s1_move;
   logic [LEN_W-1:0] cap_eff;
   logic             wr_en;
   logic [ADDR_W-1:0] wr_addr;
   logic [7:0]       wr_data;
   logic [7:0]       rx;
   logic             ea;

   assign csr_if.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         capacity_ff <= CAP_RESET;
         echo_en_ff  <= 1'b0;
      end else if (csr_if.valid) begin
         unique case (csr_index_type'(csr_if.index))
            CSR_CAPACITY:    capacity_ff <= csr_if.data;
            CSR_ECHO_ENABLE: echo_en_ff  <= csr_if.data[0];
            default: ;
         endcase
      end
   end

   always_comb begin
      if (capacity_ff == '0) begin
         cap_eff = LEN_W'(1);
      end else if (capacity_ff > CAP_W'(MAX_DEPTH)) begin
         cap_eff = LEN_W'(MAX_DEPTH);
      end else begin
         cap_eff = capacity_ff;
      end
   end

   // Flow control: the output register frees once its final result is taken.
   assign out_free      = !out_valid_ff || (rsp_if.ready && out_last_ff);
   assign s1_move       = s1_valid_ff && out_free;
   assign req_if.ready  = !s1_valid_ff || out_free;
   assign req_accept    = req_if.valid && req_if.ready;
   assign rx            = req_if.rx_byte;

   // Decode of one request against the current line state.
   always_comb begin
      fill_in     = fill_ff;
      ready_in    = ready_ff;
      ovf_in      = ovf_ff;
      echo_act_in = echo_act_ff;
      lf_pend_in  = lf_pend_ff;
      wr_en       = 1'b0;
      wr_addr     = fill_ff[ADDR_W-1:0];
      wr_data     = rx;
      ea          = echo_act_ff;
      s1_in       = '0;
      s1_in.status = ST_EMPTY;

      unique case (opcode_type'(req_if.opcode))
         OP_CLEAR: begin
            fill_in  = '0;
            ready_in = 1'b0;
            ovf_in   = 1'b0;
            wr_en    = 1'b1;
            wr_addr  = '0;
            wr_data  = 8'h00;
         end
         OP_READ: begin
            s1_in.rd_hit = {1'b0, req_if.read_index} < fill_ff;
         end
         OP_RECEIVE: begin
            lf_pend_in = 1'b0;
            priority if (lf_pend_ff && rx == CH_LF) begin
               // A line feed right after a carriage return is swallowed.
               s1_in.accepted   = 1'b1;
               s1_in.echo_valid = echo_act_ff;
               s1_in.echo_byte  = echo_act_ff ? rx : 8'h00;
            end else if (ready_ff || ovf_ff) begin
               s1_in.accepted = 1'b0;
            end else if (fill_ff >= cap_eff) begin
               // Capacity was lowered to or below the fill level.
               fill_in = cap_eff;
               ovf_in  = 1'b1;
               wr_en   = 1'b1;
               wr_addr = ADDR_W'(cap_eff - LEN_W'(1));
               wr_data = 8'h00;
            end else begin
               if (fill_ff == '0) begin
                  ea = echo_en_ff && (rx != CH_BRACE);
               end
               echo_act_in    = ea;
               s1_in.accepted = 1'b1;
               priority if (rx == CH_BS) begin
                  if (fill_ff != '0) begin
                     fill_in          = fill_ff - LEN_W'(1);
                     s1_in.echo_valid = ea;
                     s1_in.echo_byte  = ea ? CH_BS : 8'h00;
                     s1_in.dual       = ea;
                  end
               end else if (rx == CH_CR || rx == CH_NUL) begin
                  ready_in         = 1'b1;
                  lf_pend_in       = (rx == CH_CR);
                  wr_en            = 1'b1;
                  wr_data          = 8'h00;
                  fill_in          = fill_ff + LEN_W'(1);
                  s1_in.echo_valid = ea;
                  s1_in.echo_byte  = ea ? rx : 8'h00;
               end else begin
                  wr_en   = 1'b1;
                  fill_in = fill_ff + LEN_W'(1);
                  // The last free position always keeps the terminating zero.
                  if (fill_in >= cap_eff) begin
                     wr_data = 8'h00;
                     ovf_in  = 1'b1;
                  end
                  s1_in.echo_valid = ea;
                  s1_in.echo_byte  = ea ? rx : 8'h00;
               end
            end
         end
         default: ;
      endcase

      s1_in.length = fill_in;
      priority if (ready_in) begin
         s1_in.status = ST_READY;
      end else if (ovf_in) begin
         s1_in.status = ST_OVERFLOW;
      end else if (fill_in == '0) begin
         s1_in.status = ST_EMPTY;
      end else begin
         s1_in.status = ST_PARTIAL;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept && wr_en) begin
         store_mem[wr_addr] <= wr_data;
      end
      if (req_accept) begin
         mem_q_ff <= store_mem[ADDR_W'(req_if.read_index)];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff     <= '0;
         ready_ff    <= 1'b0;
         ovf_ff      <= 1'b0;
         echo_act_ff <= 1'b0;
         lf_pend_ff  <= 1'b0;
      end else if (req_accept) begin
         fill_ff     <= fill_in;
         ready_ff    <= ready_in;
         ovf_ff      <= ovf_in;
         echo_act_ff <= echo_act_in;
         lf_pend_ff  <= lf_pend_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_accept) begin
         s1_valid_ff <= 1'b1;
      end else if (s1_move) begin
         s1_valid_ff <= 1'b0;
      end
      if (req_accept) begin
         s1_ff <= s1_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
         out_last_ff  <= 1'b1;
      end else if (s1_move) begin
         out_valid_ff <= 1'b1;
         out_last_ff  <= !s1_ff.dual;
      end else if (rsp_if.ready && out_valid_ff) begin
         // The first half of a backspace echo is followed by a delete.
         out_valid_ff <= !out_last_ff;
         out_last_ff  <= 1'b1;
      end
      if (s1_move) begin
         out_ff       <= s1_ff;
         out_rdata_ff <= s1_ff.rd_hit ? mem_q_ff : 8'h00;
      end else if (rsp_if.ready && out_valid_ff && !out_last_ff) begin
         out_ff.echo_byte <= CH_DEL;
      end
   end

   assign rsp_if.valid      = out_valid_ff;
   assign rsp_if.echo_valid = out_ff.echo_valid;
   assign rsp_if.echo_byte  = out_ff.echo_byte;
   assign rsp_if.accepted   = out_ff.accepted;
   assign rsp_if.read_data  = out_rdata_ff;
   assign rsp_if.status     = out_ff.status;
   assign rsp_if.length     = out_ff.length;
   assign rsp_if.last       = out_last_ff;

   a_first_half_is_bs: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && !out_last_ff |-> out_ff.echo_byte == CH_BS)
      else $error("first half of a backspace echo is not a backspace");

   a_echo_needs_accept: assert property (@(posedge clock) disable iff (reset)
      rsp_if.valid && rsp_if.echo_valid |-> rsp_if.accepted)
      else $error("echo on a rejected request");

   a_ready_nonempty: assert property (@(posedge clock) disable iff (reset)
      ready_ff |-> fill_ff != '0)
      else $error("message ready with an empty line");

   a_stall_means_busy: assert property (@(posedge clock) disable iff (reset)
      !req_if.ready |-> s1_valid_ff && out_valid_ff)
      else $error("requests stalled while the pipeline has room");

   a_dual_second_half: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && !out_last_ff && rsp_if.ready |=> out_valid_ff && out_last_ff
         && out_ff.echo_byte == CH_DEL)
      else $error("backspace echo lost its delete");

endmodule

// ===== verif/tb_serial_line_assembler_with_echo.sv =====
// Self-checking testbench for the serial line assembler with echo.
`timescale 1ns / 1ps
module tb_serial_line_assembler_with_echo;
   import sla_pkg::*;

   localparam logic [1:0] OP_UNUSED   = 2'd3;
   localparam int         CYCLE_LIMIT = 200000;
   localparam int         STALL_LEN   = 300;
   localparam int         NUM_PHASES  = 10;
   localparam int         PHASE_ITEMS = 200;

   localparam logic [8:0] CAP_PLAN  [NUM_PHASES] = '{9'd4, 9'd2, 9'd0, 9'd1, 9'd256, 9'd300,
                                                     9'd511, 9'd8, 9'd17, 9'd33};
   localparam logic       ECHO_PLAN [NUM_PHASES] = '{1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b1,
                                                     1'b0, 1'b1, 1'b0, 1'b1};

   typedef struct packed {
      logic [1:0] opcode;
      logic [7:0] rx_byte;
      logic [7:0] read_index;
   } line_req_type;

   typedef struct packed {
      logic       echo_valid;
      logic [7:0] echo_byte;
      logic       accepted;
      logic [7:0] read_data;
      status_type status;
      logic [8:0] length;
      logic       last;
   } line_rsp_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   sla_req_if req_ch ();
   sla_rsp_if rsp_ch ();
   sla_csr_if csr_ch ();

   serial_line_assembler_with_echo dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_ch),
      .rsp_if (rsp_ch),
      .csr_if (csr_ch)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   line_req_type requests_to_send [$];
   line_rsp_type line_results_due [$];

   // Mirror of the assembler state and its registers.
   logic [7:0] model_store [MAX_DEPTH];
   logic [8:0] model_fill;
   logic       model_ready;
   logic       model_overflow;
   logic       model_echo_on;
   logic       model_lf_pending;
   logic [8:0] cfg_capacity;
   logic       cfg_echo;

   int   req_idle_pct = 0;
   int   rsp_idle_pct = 0;
   int   stim_count   = 0;
   int   mismatch_count = 0;
   int   cycle_count  = 0;
   int   stall_left;
   logic stall_go   = 1'b0;
   logic stall_used;
   logic req_taken;

   function automatic logic [8:0] effective_capacity(logic [8:0] value);
      if (value == 9'd0) return 9'd1;
      if (value > 9'(MAX_DEPTH)) return 9'(MAX_DEPTH);
      return value;
   endfunction

   function automatic void add_line_result(logic ev, logic [7:0] eb, logic acc,
                                           logic [7:0] rd, logic fin);
      line_rsp_type r;
      r.echo_valid = ev;
      r.echo_byte  = eb;
      r.accepted   = acc;
      r.read_data  = rd;
      if (model_ready) r.status = ST_READY;
      else if (model_overflow) r.status = ST_OVERFLOW;
      else if (model_fill == 9'd0) r.status = ST_EMPTY;
      else r.status = ST_PARTIAL;
      r.length = model_fill;
      r.last   = fin;
      line_results_due.push_back(r);
   endfunction

   function automatic void apply_line_request(logic [1:0] op, logic [7:0] rx, logic [7:0] ri);
      logic [8:0] cap;
      cap = effective_capacity(cfg_capacity);
      case (op)
         OP_CLEAR: begin
            model_fill     = 9'd0;
            model_store[0] = 8'h00;
            model_ready    = 1'b0;
            model_overflow = 1'b0;
            add_line_result(1'b0, 8'h00, 1'b0, 8'h00, 1'b1);
            return;
         end
         OP_READ: begin
            add_line_result(1'b0, 8'h00, 1'b0,
                            ({1'b0, ri} < model_fill) ? model_store[ri] : 8'h00, 1'b1);
            return;
         end
         OP_RECEIVE: ;
         default: begin
            add_line_result(1'b0, 8'h00, 1'b0, 8'h00, 1'b1);
            return;
         end
      endcase

      // The byte right after a carriage return gets one chance to be the line feed.
      if (model_lf_pending) begin
         model_lf_pending = 1'b0;
         if (rx == CH_LF) begin
            add_line_result(model_echo_on, model_echo_on ? rx : 8'h00, 1'b1, 8'h00, 1'b1);
            return;
         end
      end
      if (model_ready || model_overflow) begin
         add_line_result(1'b0, 8'h00, 1'b0, 8'h00, 1'b1);
         return;
      end
      // Capacity was lowered to or below the current fill level.
      if (model_fill >= cap) begin
         model_fill               = cap;
         model_store[8'(cap - 1)] = 8'h00;
         model_overflow           = 1'b1;
         add_line_result(1'b0, 8'h00, 1'b0, 8'h00, 1'b1);
         return;
      end

      if (model_fill == 9'd0) model_echo_on = cfg_echo && (rx != CH_BRACE);

      if (rx == CH_BS) begin
         if (model_fill != 9'd0) begin
            model_fill = model_fill - 9'd1;
            if (model_echo_on) begin
               add_line_result(1'b1, CH_BS, 1'b1, 8'h00, 1'b0);
               add_line_result(1'b1, CH_DEL, 1'b1, 8'h00, 1'b1);
               return;
            end
         end
         add_line_result(1'b0, 8'h00, 1'b1, 8'h00, 1'b1);
         return;
      end

      if (rx == CH_CR || rx == CH_NUL) begin
         model_ready                  = 1'b1;
         model_lf_pending             = (rx == CH_CR);
         model_store[8'(model_fill)]  = 8'h00;
         model_fill                   = model_fill + 9'd1;
      end else begin
         model_store[8'(model_fill)] = rx;
         model_fill                  = model_fill + 9'd1;
         if (model_fill >= cap) begin
            model_store[8'(cap - 1)] = 8'h00;
            model_overflow           = 1'b1;
         end
      end
      add_line_result(model_echo_on, model_echo_on ? rx : 8'h00, 1'b1, 8'h00, 1'b1);
   endfunction

   function automatic string rsp_text(line_rsp_type r);
      return $sformatf("echo %0d/%02h acc %0d data %02h status %0d len %0d last %0d",
                       r.echo_valid, r.echo_byte, r.accepted, r.read_data, r.status,
                       r.length, r.last);
   endfunction

   // Request acceptance, prediction and register mirror.
   always @(posedge clock) begin
      req_taken <= !reset && req_ch.valid && req_ch.ready;
      if (reset) begin
         model_fill       = 9'd0;
         model_ready      = 1'b0;
         model_overflow   = 1'b0;
         model_echo_on    = 1'b0;
         model_lf_pending = 1'b0;
         cfg_capacity     = CAP_RESET;
         cfg_echo         = 1'b0;
      end else begin
         if (req_ch.valid && req_ch.ready) begin
            apply_line_request(req_ch.opcode, req_ch.rx_byte, req_ch.read_index);
            void'(requests_to_send.pop_front());
         end
         if (csr_ch.valid && csr_ch.ready) begin
            case (csr_ch.index)
               CSR_CAPACITY:    cfg_capacity = csr_ch.data;
               CSR_ECHO_ENABLE: cfg_echo     = csr_ch.data[0];
               default: ;
            endcase
         end
      end
   end

   always @(negedge clock) begin
      if (reset) begin
         req_ch.valid <= 1'b0;
      end else if (!req_ch.valid || req_taken) begin
         if (requests_to_send.size() != 0 && $urandom_range(99) >= req_idle_pct) begin
            req_ch.valid      <= 1'b1;
            req_ch.opcode     <= requests_to_send[0].opcode;
            req_ch.rx_byte    <= requests_to_send[0].rx_byte;
            req_ch.read_index <= requests_to_send[0].read_index;
         end else begin
            req_ch.valid <= 1'b0;
         end
      end
   end

   // Long receiver hold-off, triggered once.
   always @(posedge clock) begin
      if (reset) begin
         stall_left <= 0;
         stall_used <= 1'b0;
      end else if (stall_go && !stall_used) begin
         stall_left <= STALL_LEN;
         stall_used <= 1'b1;
      end else if (stall_left != 0) begin
         stall_left <= stall_left - 1;
      end
   end

   always @(negedge clock) begin
      if (reset || stall_left != 0) rsp_ch.ready <= 1'b0;
      else rsp_ch.ready <= ($urandom_range(99) >= rsp_idle_pct);
   end

   always @(posedge clock) begin
      line_rsp_type seen;
      line_rsp_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         seen.echo_valid = rsp_ch.echo_valid;
         seen.echo_byte  = rsp_ch.echo_byte;
         seen.accepted   = rsp_ch.accepted;
         seen.read_data  = rsp_ch.read_data;
         seen.status     = status_type'(rsp_ch.status);
         seen.length     = rsp_ch.length;
         seen.last       = rsp_ch.last;
         if (line_results_due.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10) $display("unexpected result: %s", rsp_text(seen));
         end else begin
            want = line_results_due.pop_front();
            if (seen !== want) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("result mismatch: expected %s, got %s",
                           rsp_text(want), rsp_text(seen));
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("end of test: mismatches");
         $finish;
      end
   end

   function automatic void queue_request(logic [1:0] op, logic [7:0] rx, logic [7:0] ri);
      line_req_type item;
      item.opcode     = op;
      item.rx_byte    = rx;
      item.read_index = ri;
      requests_to_send.push_back(item);
      if (op != OP_UNUSED) stim_count++;
   endfunction

   function automatic logic [7:0] printable_byte();
      return 8'($urandom_range(8'h7e, 8'h20));
   endfunction

   task automatic gen_line(int cap_eff, bit long_line);
      int         len;
      int         pick;
      logic [7:0] ch;
      len = long_line ? cap_eff - 1 + $urandom_range(2)
                      : $urandom_range((cap_eff < 12) ? cap_eff + 1 : 12);
      for (int k = 0; k < len; k++) begin
         pick = $urandom_range(19);
         if (k == 0 && pick < 4) ch = CH_BRACE;
         else if (!long_line && pick >= 17) ch = CH_BS;
         else if (!long_line && pick == 16) ch = 8'($urandom_range(255));
         else ch = printable_byte();
         queue_request(OP_RECEIVE, ch, 8'($urandom_range(255)));
      end
      pick = $urandom_range(9);
      if (pick <= 5) begin
         queue_request(OP_RECEIVE, CH_CR, 8'($urandom_range(255)));
         if ($urandom_range(3) != 0) queue_request(OP_RECEIVE, CH_LF, 8'($urandom_range(255)));
      end else if (pick <= 8) begin
         queue_request(OP_RECEIVE, CH_NUL, 8'($urandom_range(255)));
      end
      // Bytes after the end of a message should be turned away.
      if ($urandom_range(2) == 0)
         repeat ($urandom_range(1, 3))
            queue_request(OP_RECEIVE, 8'($urandom_range(255)), 8'($urandom_range(255)));
      repeat ($urandom_range(3))
         queue_request(OP_READ, 8'($urandom_range(255)),
                       ($urandom_range(3) == 0) ? 8'($urandom_range(255))
                       : 8'($urandom_range((len + 2 > 255) ? 255 : len + 2)));
      if ($urandom_range(9) != 0)
         queue_request(OP_CLEAR, 8'($urandom_range(255)), 8'($urandom_range(255)));
   endtask

   task automatic gen_phase(int target, int cap_eff, bit with_long_line);
      int start;
      start = stim_count;
      // The first byte of a phase meets whatever partial line the last phase left.
      queue_request(OP_RECEIVE, printable_byte(), 8'h00);
      if (with_long_line) begin
         queue_request(OP_CLEAR, 8'h00, 8'h00);
         gen_line(cap_eff, 1'b1);
      end
      while (stim_count - start < target) begin
         if ($urandom_range(5) == 0) begin
            repeat ($urandom_range(1, 5))
               queue_request(2'($urandom_range(3)), 8'($urandom_range(255)),
                             8'($urandom_range(255)));
         end else begin
            gen_line(cap_eff, 1'b0);
         end
      end
      queue_request(OP_CLEAR, 8'h00, 8'h00);
      repeat ($urandom_range(1, 6)) queue_request(OP_RECEIVE, printable_byte(), 8'h00);
   endtask

   task automatic gen_directed();
      queue_request(OP_RECEIVE, CH_BS, 8'h00);   // backspace on an empty line
      queue_request(OP_RECEIVE, 8'h61, 8'hff);
      queue_request(OP_RECEIVE, CH_BS, 8'h00);
      queue_request(OP_RECEIVE, 8'hff, 8'h00);
      queue_request(OP_RECEIVE, 8'h62, 8'h00);
      queue_request(OP_RECEIVE, 8'h63, 8'h00);
      queue_request(OP_RECEIVE, 8'h64, 8'h00);   // reaches capacity
      queue_request(OP_RECEIVE, 8'h65, 8'h00);
      queue_request(OP_READ, 8'h00, 8'h00);
      queue_request(OP_READ, 8'h00, 8'h03);
      queue_request(OP_READ, 8'hff, 8'hff);
      queue_request(OP_CLEAR, 8'h00, 8'h00);
      queue_request(OP_RECEIVE, CH_BRACE, 8'h00);
      queue_request(OP_RECEIVE, 8'h78, 8'h00);
      queue_request(OP_RECEIVE, CH_CR, 8'h00);
      queue_request(OP_RECEIVE, CH_LF, 8'h00);
      queue_request(OP_UNUSED, 8'hff, 8'hff);
      queue_request(OP_CLEAR, 8'h00, 8'h00);
      queue_request(OP_RECEIVE, CH_NUL, 8'h00);
      queue_request(OP_RECEIVE, CH_LF, 8'h00);   // no carriage return before it
      queue_request(OP_CLEAR, 8'h00, 8'h00);
      queue_request(OP_RECEIVE, 8'h70, 8'h00);
      queue_request(OP_RECEIVE, CH_CR, 8'h00);
      queue_request(OP_CLEAR, 8'h00, 8'h00);
      queue_request(OP_RECEIVE, CH_LF, 8'h00);   // a clear keeps the pending line feed
      queue_request(OP_RECEIVE, 8'h71, 8'h00);
      queue_request(OP_RECEIVE, 8'h72, 8'h00);
   endtask

   task automatic write_register(csr_index_type idx, logic [8:0] value);
      @(negedge clock);
      csr_ch.valid <= 1'b1;
      csr_ch.index <= idx;
      csr_ch.data  <= value;
      do @(posedge clock); while (!csr_ch.ready);
      @(negedge clock);
      csr_ch.valid <= 1'b0;
   endtask

   task automatic wait_drained();
      while (requests_to_send.size() != 0 || line_results_due.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   initial begin
      int mode;
      req_ch.valid      = 1'b0;
      req_ch.opcode     = OP_RECEIVE;
      req_ch.rx_byte    = 8'h00;
      req_ch.read_index = 8'h00;
      rsp_ch.ready      = 1'b0;
      csr_ch.valid      = 1'b0;
      csr_ch.index      = CSR_CAPACITY;
      csr_ch.data       = 9'd0;

      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      for (int p = 0; p < NUM_PHASES; p++) begin
         write_register(CSR_CAPACITY, CAP_PLAN[p]);
         write_register(CSR_ECHO_ENABLE, 9'(ECHO_PLAN[p]));
         mode = (p == 0) ? 0 : (p - 1) / 3;
         req_idle_pct = (mode == 0) ? 10 : (mode == 1) ? 59 : 0;
         rsp_idle_pct = (mode == 0) ? 59 : (mode == 1) ? 10 : 0;
         if (p == 0) gen_directed();
         else gen_phase(PHASE_ITEMS, int'(effective_capacity(CAP_PLAN[p])), p == 4);
         if (p == 2) stall_go = 1'b1;
         wait_drained();
      end

      repeat (8) @(posedge clock);
      if (mismatch_count == 0 && line_results_due.size() == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule

// ===== files.f =====
rtl/sla_pkg.sv
rtl/sla_if.sv
rtl/serial_line_assembler_with_echo.sv
verif/tb_serial_line_assembler_with_echo.sv
